@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/nrmc_pkg.sv @@
// ---------------------------------------------------------------------------
// nrmc_pkg
// Shared types, characters and scaling constants of the RMC position parser.
// ---------------------------------------------------------------------------
`default_nettype none

package nrmc_pkg;

    // default configuration
    localparam int LINE_LEN_DEF        = 128;
    localparam int MAX_FRAC_DIGITS_DEF = 6;

    // fixed widths
    localparam int INT_W  = 17;  // integer digits, saturated at 99999
    localparam int CNT_W  = 3;   // fraction digit count
    localparam int FLD_W  = 3;   // field number, saturated at 7
    localparam int FS_W   = 24;  // scaled fraction, below 10^7
    localparam int DEG_W  = 10;  // whole degrees, below 1000
    localparam int MIN_W  = 7;   // whole minutes, below 100
    localparam int TOT_W  = 30;  // minutes * 10^7 plus fraction, below 10^9
    localparam int DEGS_W = 34;  // degrees * 10^7
    localparam int TQ_W   = 25;  // total / 60
    localparam int MAG_W  = 35;  // unsaturated magnitude

    // characters
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;

    // field numbers
    localparam logic [FLD_W-1:0] FLD_STATUS = 3'd2;
    localparam logic [FLD_W-1:0] FLD_LAT    = 3'd3;
    localparam logic [FLD_W-1:0] FLD_NS     = 3'd4;
    localparam logic [FLD_W-1:0] FLD_LON    = 3'd5;
    localparam logic [FLD_W-1:0] FLD_EW     = 3'd6;
    localparam logic [FLD_W-1:0] FLD_LAST   = 3'd7;

    // arithmetic constants
    localparam logic [INT_W-1:0] INT_SAT    = 17'd99999;
    localparam logic [FS_W-1:0]  SCALE      = 24'd10000000;
    localparam logic [17:0]      DIV100_MUL = 18'd167773;     // ceil(2^24 / 100)
    localparam int               DIV100_SH  = 24;
    localparam logic [28:0]      DIV15_MUL  = 29'd286331154;  // ceil(2^32 / 15)
    localparam int               DIV15_SH   = 32;
    localparam logic [31:0]      MAG_SAT    = 32'h8000_0000;
    localparam logic [31:0]      POS_MAX    = 32'h7FFF_FFFF;

    // event handed from the parser down the conversion pipeline
    typedef struct packed {
        logic conv;    // a coordinate field ends here
        logic lon;     // that field is the longitude
        logic nl;      // sentence end
        logic rmc;     // sentence carried the RMC tag
        logic status;  // status field began with 'A'
        logic south;
        logic west;
    } nrmc_evt_t;

    // 10^(7-n): scale of a fraction with n digits to units of 10^-7
    function automatic logic [FS_W-1:0] frac_scale(input logic [CNT_W-1:0] n);
        logic [FS_W-1:0] s;
        case (n)
            3'd0:    s = 24'd10000000;
            3'd1:    s = 24'd1000000;
            3'd2:    s = 24'd100000;
            3'd3:    s = 24'd10000;
            3'd4:    s = 24'd1000;
            3'd5:    s = 24'd100;
            3'd6:    s = 24'd10;
            default: s = 24'd1;
        endcase
        return s;
    endfunction

    // signed coordinate from magnitude and hemisphere
    function automatic logic signed [31:0] apply_sign(input logic [31:0] mag,
                                                      input logic neg);
        logic [31:0] v;
        if (neg)
            v = 32'd0 - mag;
        else if (mag > POS_MAX)
            v = POS_MAX;
        else
            v = mag;
        return $signed(v);
    endfunction

endpackage

`default_nettype wire

@@ hdl/nrmc_parse.sv @@
// ---------------------------------------------------------------------------
// nrmc_parse
// Per-character sentence parser; registers one event per accepted byte.
// ---------------------------------------------------------------------------
`default_nettype none

module nrmc_parse
    import nrmc_pkg::*;
#(
    parameter int LINE_LEN        = LINE_LEN_DEF,
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF,
    parameter int FRAC_W          = $clog2(10 ** MAX_FRAC_DIGITS)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               advance,
    output logic                    evt_valid_reg,
    output nrmc_evt_t               evt_reg,
    output logic [INT_W-1:0]        int_reg,
    output logic [FRAC_W-1:0]       frac_reg,
    output logic [CNT_W-1:0]        cnt_reg
);

    localparam int POS_W = $clog2(LINE_LEN);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              term_reg, term_next;
    logic [FLD_W-1:0]  fld_reg, fld_next;
    logic              tag_reg, tag_next;
    logic              status_reg, status_next;
    logic              first_reg, first_next;
    logic [INT_W-1:0]  idig_reg, idig_next;
    logic [FRAC_W-1:0] fdig_reg, fdig_next;
    logic [CNT_W-1:0]  fcnt_reg, fcnt_next;
    logic              point_reg, point_next;
    logic              south_reg, south_next;
    logic              west_reg, west_next;

    logic              accept;
    logic              coord_fld;
    logic [3:0]        digit;
    logic [19:0]       int_acc;
    logic [FRAC_W+3:0] frac_acc;
    nrmc_evt_t         evt_next;

    assign accept    = in_valid && advance;
    assign coord_fld = (fld_reg == FLD_LAT) || (fld_reg == FLD_LON);
    assign digit     = 4'(rx_byte - CH_ZERO);
    assign int_acc   = 20'(idig_reg) * 20'd10 + 20'(digit);
    assign frac_acc  = (FRAC_W+4)'(fdig_reg) * (FRAC_W+4)'(10) + (FRAC_W+4)'(digit);

    // character decode and line state update
    always_comb
    begin
        pos_next    = pos_reg;
        term_next   = term_reg;
        fld_next    = fld_reg;
        tag_next    = tag_reg;
        status_next = status_reg;
        first_next  = first_reg;
        idig_next   = idig_reg;
        fdig_next   = fdig_reg;
        fcnt_next   = fcnt_reg;
        point_next  = point_reg;
        south_next  = south_reg;
        west_next   = west_reg;
        evt_next    = '0;

        if (accept)
        begin
            if (rx_byte == CH_NL)
            begin
                // close the sentence and restart line state
                evt_next.nl     = 1'b1;
                evt_next.conv   = coord_fld;
                evt_next.lon    = (fld_reg == FLD_LON);
                evt_next.rmc    = tag_reg && (pos_reg >= POS_W'(6));
                evt_next.status = status_reg;
                evt_next.south  = south_reg;
                evt_next.west   = west_reg;
                pos_next    = '0;
                term_next   = 1'b0;
                fld_next    = '0;
                tag_next    = 1'b1;
                status_next = 1'b0;
                first_next  = 1'b1;
                idig_next   = '0;
                fdig_next   = '0;
                fcnt_next   = '0;
                point_next  = 1'b0;
                south_next  = 1'b0;
                west_next   = 1'b0;
            end
            else if (!term_reg)
            begin
                if (rx_byte == CH_NUL)
                begin
                    term_next = 1'b1;
                end
                else if (pos_reg < POS_W'(LINE_LEN - 1))
                begin
                    // tag check at positions 3 to 5
                    if (pos_reg == POS_W'(3) && rx_byte != CH_R)
                        tag_next = 1'b0;
                    if (pos_reg == POS_W'(4) && rx_byte != CH_M)
                        tag_next = 1'b0;
                    if (pos_reg == POS_W'(5) && rx_byte != CH_C)
                        tag_next = 1'b0;
                    pos_next = pos_reg + POS_W'(1);

                    if (rx_byte == CH_COMMA)
                    begin
                        // end of field: hand digits to the converter
                        evt_next.conv = coord_fld;
                        evt_next.lon  = (fld_reg == FLD_LON);
                        idig_next  = '0;
                        fdig_next  = '0;
                        fcnt_next  = '0;
                        point_next = 1'b0;
                        if (fld_reg != FLD_LAST)
                            fld_next = fld_reg + FLD_W'(1);
                        first_next = 1'b1;
                    end
                    else
                    begin
                        if (first_reg)
                        begin
                            if (fld_reg == FLD_STATUS)
                                status_next = (rx_byte == CH_A);
                            if (fld_reg == FLD_NS)
                                south_next = (rx_byte == CH_S);
                            if (fld_reg == FLD_EW)
                                west_next = (rx_byte == CH_W);
                            first_next = 1'b0;
                        end
                        if (coord_fld)
                        begin
                            if (rx_byte == CH_POINT)
                            begin
                                point_next = 1'b1;
                            end
                            else if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE)
                            begin
                                if (!point_reg)
                                begin
                                    idig_next = (int_acc > 20'(INT_SAT)) ? INT_SAT
                                                                          : int_acc[INT_W-1:0];
                                end
                                else if (fcnt_reg < CNT_W'(MAX_FRAC_DIGITS))
                                begin
                                    fdig_next = frac_acc[FRAC_W-1:0];
                                    fcnt_next = fcnt_reg + CNT_W'(1);
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            term_reg   <= 1'b0;
            fld_reg    <= '0;
            tag_reg    <= 1'b1;
            status_reg <= 1'b0;
            first_reg  <= 1'b1;
            idig_reg   <= '0;
            fdig_reg   <= '0;
            fcnt_reg   <= '0;
            point_reg  <= 1'b0;
            south_reg  <= 1'b0;
            west_reg   <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            term_reg   <= term_next;
            fld_reg    <= fld_next;
            tag_reg    <= tag_next;
            status_reg <= status_next;
            first_reg  <= first_next;
            idig_reg   <= idig_next;
            fdig_reg   <= fdig_next;
            fcnt_reg   <= fcnt_next;
            point_reg  <= point_next;
            south_reg  <= south_next;
            west_reg   <= west_next;
        end
    end

    // event register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            evt_valid_reg <= 1'b0;
        else if (advance)
            evt_valid_reg <= accept;
    end

    // event register: payload snapshot before the field clears
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            evt_reg  <= evt_next;
            int_reg  <= idig_reg;
            frac_reg <= fdig_reg;
            cnt_reg  <= fcnt_reg;
        end
    end

endmodule

`default_nettype wire

@@ hdl/nrmc_conv.sv @@
// ---------------------------------------------------------------------------
// nrmc_conv
// Four-stage conversion of ddmm.mmmm digits to degrees * 10^7 parts.
// ---------------------------------------------------------------------------
`default_nettype none

module nrmc_conv
    import nrmc_pkg::*;
#(
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF,
    parameter int FRAC_W          = $clog2(10 ** MAX_FRAC_DIGITS)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              evt_valid,
    input  wire nrmc_evt_t         evt,
    input  wire logic [INT_W-1:0]  int_digits,
    input  wire logic [FRAC_W-1:0] frac_val,
    input  wire logic [CNT_W-1:0]  frac_count,
    output logic                   d_valid_reg,
    output nrmc_evt_t              d_evt_reg,
    output logic [DEGS_W-1:0]      d_degs_reg,
    output logic [TQ_W-1:0]        d_tq_reg
);

    localparam int QF_W = INT_W + 18;
    localparam int FF_W = FRAC_W + FS_W;

    logic              a_valid_reg, b_valid_reg, c_valid_reg;
    nrmc_evt_t         a_evt_reg, b_evt_reg, c_evt_reg;
    logic [INT_W-1:0]  a_int_reg;
    logic [DEG_W-1:0]  a_deg_reg, b_deg_reg;
    logic [FS_W-1:0]   a_fs_reg, b_fs_reg;
    logic [MIN_W-1:0]  b_min_reg;
    logic [TOT_W-1:0]  c_tot_reg;
    logic [DEGS_W-1:0] c_degs_reg;

    logic [QF_W-1:0]   q_full;
    logic [FF_W-1:0]   fs_full;
    logic [INT_W-1:0]  hundreds;
    logic [INT_W-1:0]  rem_full;
    logic [30:0]       min_units;
    logic [56:0]       tq_full;

    // stage A: degrees by reciprocal of 100, fraction to 10^-7 units
    assign q_full  = QF_W'(int_digits) * QF_W'(DIV100_MUL);
    assign fs_full = FF_W'(frac_val) * FF_W'(frac_scale(frac_count));

    // stage B: minutes are what the degrees leave
    assign hundreds = INT_W'(a_deg_reg) * INT_W'(100);
    assign rem_full = a_int_reg - hundreds;

    // stage C: total in 10^-7 minutes, degrees in 10^-7 degrees
    assign min_units = 31'(b_min_reg) * 31'(SCALE);

    // stage D: divide by 60 as shift by 2 then reciprocal of 15
    assign tq_full = 57'(c_tot_reg[TOT_W-1:2]) * 57'(DIV15_MUL);

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= evt_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_evt_reg  <= evt;
            a_int_reg  <= int_digits;
            a_deg_reg  <= q_full[DIV100_SH +: DEG_W];
            a_fs_reg   <= fs_full[FS_W-1:0];

            b_evt_reg  <= a_evt_reg;
            b_deg_reg  <= a_deg_reg;
            b_fs_reg   <= a_fs_reg;
            b_min_reg  <= rem_full[MIN_W-1:0];

            c_evt_reg  <= b_evt_reg;
            c_tot_reg  <= TOT_W'(min_units) + TOT_W'(b_fs_reg);
            c_degs_reg <= DEGS_W'(b_deg_reg) * DEGS_W'(SCALE);

            d_evt_reg  <= c_evt_reg;
            d_degs_reg <= c_degs_reg;
            d_tq_reg   <= tq_full[DIV15_SH +: TQ_W];
        end
    end

endmodule

`default_nettype wire

@@ hdl/nrmc_commit.sv @@
// ---------------------------------------------------------------------------
// nrmc_commit
// Coordinate saturation, pending coordinates, stored fix and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module nrmc_commit
    import nrmc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              d_valid,
    input  wire nrmc_evt_t         d_evt,
    input  wire logic [DEGS_W-1:0] d_degs,
    input  wire logic [TQ_W-1:0]   d_tq,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output logic                   fix_valid,
    output logic signed [31:0]     latitude,
    output logic signed [31:0]     longitude,
    output logic                   was_rmc
);

    logic [31:0]        plat_reg, plat_next;
    logic [31:0]        plon_reg, plon_next;
    logic               fix_reg, fix_next;
    logic signed [31:0] lat_reg, lat_next;
    logic signed [31:0] lon_reg, lon_next;
    logic               rmc_reg, rmc_next;
    logic               ovalid_reg, ovalid_next;

    logic               fire;
    logic [MAG_W-1:0]   mag_sum;
    logic [31:0]        mag;
    logic [31:0]        lat_src;
    logic [31:0]        lon_src;

    assign fire    = d_valid && advance;
    assign mag_sum = MAG_W'(d_degs) + MAG_W'(d_tq);
    assign mag     = (mag_sum > MAG_W'(MAG_SAT)) ? MAG_SAT : mag_sum[31:0];
    assign lat_src = (d_evt.conv && !d_evt.lon) ? mag : plat_reg;
    assign lon_src = (d_evt.conv && d_evt.lon) ? mag : plon_reg;

    // commit field ends and sentence ends
    always_comb
    begin
        plat_next   = plat_reg;
        plon_next   = plon_reg;
        fix_next    = fix_reg;
        lat_next    = lat_reg;
        lon_next    = lon_reg;
        rmc_next    = rmc_reg;
        ovalid_next = ovalid_reg && out_stall;

        if (fire)
        begin
            if (d_evt.nl)
            begin
                if (d_evt.rmc)
                begin
                    fix_next = d_evt.status;
                    if (d_evt.status)
                    begin
                        lat_next = apply_sign(lat_src, d_evt.south);
                        lon_next = apply_sign(lon_src, d_evt.west);
                    end
                end
                rmc_next    = d_evt.rmc;
                ovalid_next = 1'b1;
                plat_next   = '0;
                plon_next   = '0;
            end
            else if (d_evt.conv)
            begin
                plat_next = lat_src;
                plon_next = lon_src;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plat_reg   <= '0;
            plon_reg   <= '0;
            fix_reg    <= 1'b0;
            lat_reg    <= '0;
            lon_reg    <= '0;
            rmc_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            plat_reg   <= plat_next;
            plon_reg   <= plon_next;
            fix_reg    <= fix_next;
            lat_reg    <= lat_next;
            lon_reg    <= lon_next;
            rmc_reg    <= rmc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;
    assign fix_valid = fix_reg;
    assign latitude  = lat_reg;
    assign longitude = lon_reg;
    assign was_rmc   = rmc_reg;

endmodule

`default_nettype wire

@@ hdl/nmea_rmc_position_parser_top.sv @@
// ---------------------------------------------------------------------------
// nmea_rmc_position_parser_top
// Takes NMEA text one byte per cycle while in_stall is low and gives the
// stored fix, latitude and longitude (degrees * 10^7, south and west
// negative) at every newline, with was_rmc telling whether that sentence
// was an RMC sentence. Throughput is one byte per cycle while in_stall is
// low. The parse register loads on the accepting edge, then four
// conversion stages (divide by 100, minutes, scaling, divide by 60) and the
// result register follow. The input stalls only while a newline sits in the
// last conversion stage and the previous result is still held by out_stall.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nmea_rmc_position_parser_top
    import nrmc_pkg::*;
#(
    parameter int LINE_LEN        = LINE_LEN_DEF,
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [7:0]   rx_byte,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic              fix_valid,
    output logic signed [31:0] latitude,
    output logic signed [31:0] longitude,
    output logic              was_rmc
);

    localparam int FRAC_W = $clog2(10 ** MAX_FRAC_DIGITS);

    logic              advance;
    logic              nl_commit;
    logic              e_valid;
    nrmc_evt_t         e_evt;
    logic [INT_W-1:0]  e_int;
    logic [FRAC_W-1:0] e_frac;
    logic [CNT_W-1:0]  e_cnt;
    logic              d_valid;
    nrmc_evt_t         d_evt;
    logic [DEGS_W-1:0] d_degs;
    logic [TQ_W-1:0]   d_tq;

    // hold the whole pipeline only when a result would overwrite a waiting one
    assign advance  = !(d_valid && d_evt.nl && out_valid && out_stall);
    assign in_stall = !advance;

    // sentence end leaving the last conversion stage
    assign nl_commit = d_valid && d_evt.nl && advance;

    nrmc_parse #(
        .LINE_LEN        (LINE_LEN),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
        .FRAC_W          (FRAC_W)
    ) u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .rx_byte       (rx_byte),
        .advance       (advance),
        .evt_valid_reg (e_valid),
        .evt_reg       (e_evt),
        .int_reg       (e_int),
        .frac_reg      (e_frac),
        .cnt_reg       (e_cnt)
    );

    nrmc_conv #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
        .FRAC_W          (FRAC_W)
    ) u_conv (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .evt_valid   (e_valid),
        .evt         (e_evt),
        .int_digits  (e_int),
        .frac_val    (e_frac),
        .frac_count  (e_cnt),
        .d_valid_reg (d_valid),
        .d_evt_reg   (d_evt),
        .d_degs_reg  (d_degs),
        .d_tq_reg    (d_tq)
    );

    nrmc_commit u_commit (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .d_valid   (d_valid),
        .d_evt     (d_evt),
        .d_degs    (d_degs),
        .d_tq      (d_tq),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .fix_valid (fix_valid),
        .latitude  (latitude),
        .longitude (longitude),
        .was_rmc   (was_rmc)
    );

    // a stalled input always means a result is waiting at the output
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
    // a committed sentence end always presents a result
    `ASSERT_NEXT(a_nl_result, clk, rst_n, nl_commit, out_valid)
    // stored coordinates move only at a committed sentence end
    `ASSERT_NEXT(a_coord_hold, clk, rst_n, !nl_commit, $stable({fix_valid, latitude, longitude}))

endmodule

`default_nettype wire
